// ===== src/cld_pkg.sv =====
// shared constants for the console line discipline
package cld_pkg;

    localparam int LINE_LEN = 64;
    localparam int ADDR_W   = $clog2(LINE_LEN);
    localparam int CNT_W    = $clog2(LINE_LEN + 1);

    localparam logic [7:0] KEY_NUL       = 8'h00;
    localparam logic [7:0] KEY_EOF       = 8'h04;
    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
    localparam logic [7:0] KEY_KILL      = 8'h15;

endpackage

// ===== src/console_line_discipline.sv =====
// console line discipline: line editing over a line buffer ram, released lines streamed out
//
//  channel   dir  payload                                     transfer when
//  s_axis    in   tdata = key_byte, tuser = more_pending      tvalid & tready
//  m_axis    out  tdata = line_byte, tuser = empty_line,      tvalid & tready
//                 tlast = last_of_line
//  cfg       in   cfg_wdata[0] = raw_mode                     cfg_we
//
// a key byte that releases nothing is taken at once, so such keys can come back to back.
// the line buffer is a single-port ram with a registered read (mem_q). a released
// line of n bytes streams out one byte per cycle while the output is not stalled;
// its first byte is valid once the drain state has read it into mem_q and mem_q
// has been loaded into the output register, and the next key is taken only after
// the last read has reached the output register. an empty release gives a single
// result through empty_pend; the next key waits until it is loaded. reset clears
// the fill count, the mode and all handshake state; the buffer contents are not
// cleared. output stalls hold the output register and stop ram reads, losing no data.
module console_line_discipline
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,          // raw_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,       // [7:0] key_byte
    input  logic       s_axis_tuser,       // more_pending
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,       // [7:0] line_byte
    output logic       m_axis_tuser,       // empty_line
    output logic       m_axis_tlast        // last_of_line
);
    import cld_pkg::*;

    localparam logic [0:0] S_IDLE  = 1'b0;
    localparam logic [0:0] S_DRAIN = 1'b1;

    logic [7:0] line_mem [LINE_LEN];
    logic [7:0] mem_q;

    logic [0:0]        state_reg,      state_next;
    logic [CNT_W-1:0]  fill_reg,       fill_next;
    logic [ADDR_W-1:0] rd_idx_reg,     rd_idx_next;
    logic [ADDR_W-1:0] drain_last_reg, drain_last_next;
    logic              raw_mode_reg;
    logic              rd_pend_reg,    rd_pend_next;
    logic              rd_last_reg,    rd_last_next;
    logic              empty_pend_reg, empty_pend_next;
    logic              out_valid_reg,  out_valid_next;
    logic [7:0]        out_data_reg,   out_data_next;
    logic              out_user_reg,   out_user_next;
    logic              out_last_reg,   out_last_next;

    logic              in_xfer;
    logic              out_free;
    logic              load_rd;
    logic              load_empty;
    logic              rd_issue;
    logic              do_store;
    logic              mem_we;
    logic              release_line;
    logic [CNT_W-1:0]  fill_edit;
    logic [CNT_W-1:0]  fill_after;

    assign s_axis_tready = (state_reg == S_IDLE) && !rd_pend_reg && !empty_pend_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign load_rd       = rd_pend_reg && out_free;
    assign load_empty    = empty_pend_reg && out_free;
    assign rd_issue      = (state_reg == S_DRAIN) && (!rd_pend_reg || load_rd);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // key decode: editing, store decision and release decision
    always_comb
    begin
        do_store     = 1'b0;
        release_line = 1'b0;
        fill_edit    = fill_reg;
        if (s_axis_tdata == KEY_NUL)
        begin
            release_line = (fill_reg != '0) && !s_axis_tuser;
        end
        else if (raw_mode_reg)
        begin
            do_store     = 1'b1;
            release_line = !s_axis_tuser;
        end
        else
        begin
            case (s_axis_tdata)
                KEY_BACKSPACE:
                begin
                    if (fill_reg != '0)
                    begin
                        fill_edit = fill_reg - CNT_W'(1);
                    end
                end
                KEY_KILL:
                begin
                    fill_edit = '0;
                end
                KEY_EOF:
                begin
                    release_line = 1'b1;
                end
                KEY_NEWLINE:
                begin
                    do_store     = 1'b1;
                    release_line = 1'b1;
                end
                default:
                begin
                    do_store = 1'b1;
                end
            endcase
        end
        mem_we     = in_xfer && do_store && (fill_reg < CNT_W'(LINE_LEN));
        fill_after = mem_we ? fill_reg + CNT_W'(1) : fill_edit;
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        rd_idx_next     = rd_idx_reg;
        drain_last_next = drain_last_reg;
        empty_pend_next = empty_pend_reg && !load_empty;
        rd_pend_next    = rd_issue ? 1'b1 : (rd_pend_reg && !load_rd);
        rd_last_next    = rd_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (release_line || (fill_after == CNT_W'(LINE_LEN)))
                    begin
                        fill_next = '0;
                        if (fill_after == '0)
                        begin
                            empty_pend_next = 1'b1;
                        end
                        else
                        begin
                            state_next      = S_DRAIN;
                            rd_idx_next     = '0;
                            drain_last_next = ADDR_W'(fill_after - CNT_W'(1));
                        end
                    end
                    else
                    begin
                        fill_next = fill_after;
                    end
                end
            end
            S_DRAIN:
            begin
                if (rd_issue)
                begin
                    rd_last_next = (rd_idx_reg == drain_last_reg);
                    if (rd_idx_reg == drain_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // ram data or the end-of-file marker moves into the output register
        if (load_rd)
        begin
            out_valid_next = 1'b1;
            out_data_next  = mem_q;
            out_user_next  = 1'b0;
            out_last_next  = rd_last_reg;
        end
        else if (load_empty)
        begin
            out_valid_next = 1'b1;
            out_data_next  = KEY_NUL;
            out_user_next  = 1'b1;
            out_last_next  = 1'b1;
        end
    end

    // line buffer ram, mem_q holds its value until the next read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[fill_reg[ADDR_W-1:0]] <= s_axis_tdata;
        end
        if (rd_issue)
        begin
            mem_q <= line_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            raw_mode_reg   <= 1'b0;
            rd_pend_reg    <= 1'b0;
            empty_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            rd_pend_reg    <= rd_pend_next;
            empty_pend_reg <= empty_pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                raw_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        drain_last_reg <= drain_last_next;
        rd_last_reg    <= rd_last_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
        out_last_reg   <= out_last_next;
    end

endmodule
